@@ rtl/firc_pkg.sv @@
// ----------------------------------------------------------------------------
// firc_pkg: shared types and constants of the circular fir filter
// sizes, coefficient table, tap control word and sequencer states
// ----------------------------------------------------------------------------
package firc_pkg;

  localparam int TAPS       = 121;
  localparam int COEF_WIDTH = 16;
  localparam int SAMPLE_W   = 16;

  localparam int TAP_W    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int FILL_W   = $clog2(TAPS + 1);
  localparam int PROD_W   = SAMPLE_W + COEF_WIDTH;
  localparam int ACC_W    = PROD_W + TAP_W;
  localparam int FRAC_W   = COEF_WIDTH - 1;

  // stored half of the symmetric q1.15 table
  localparam int ROM_LEN   = 121;
  localparam int ROM_HALF  = 61;
  localparam int ROM_W     = 16;
  localparam int ROM_IDX_W = $clog2(ROM_HALF);
  localparam int CW_MAX    = 24;
  localparam int COEF_UP   = (COEF_WIDTH >= ROM_W) ? COEF_WIDTH - ROM_W : 0;
  localparam int COEF_DN   = (COEF_WIDTH < ROM_W) ? ROM_W - COEF_WIDTH : 0;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (SAMPLE_W - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  localparam logic signed [ROM_W-1:0] ROM_TBL [ROM_HALF] = '{
    16'sd133,   16'sd112,   16'sd81,    16'sd41,    -16'sd6,
    -16'sd57,   -16'sd110,  -16'sd161,  -16'sd207,  -16'sd245,
    -16'sd272,  -16'sd287,  -16'sd288,  -16'sd275,  -16'sd249,
    -16'sd213,  -16'sd169,  -16'sd121,  -16'sd74,   -16'sd32,
    16'sd2,     16'sd24,    16'sd31,    16'sd23,    -16'sd1,
    -16'sd40,   -16'sd89,   -16'sd145,  -16'sd201,  -16'sd253,
    -16'sd292,  -16'sd312,  -16'sd309,  -16'sd277,  -16'sd214,
    -16'sd120,  16'sd6,     16'sd157,   16'sd329,   16'sd514,
    16'sd700,   16'sd878,   16'sd1036,  16'sd1162,  16'sd1247,
    16'sd1283,  16'sd1262,  16'sd1182,  16'sd1042,  16'sd845,
    16'sd599,   16'sd311,   -16'sd4,    -16'sd335,  -16'sd664,
    -16'sd977,  -16'sd1257, -16'sd1492, -16'sd1668, -16'sd1778,
    16'sd30953
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT
  } state_t;

  // control word that travels beside the delay line read data
  typedef struct packed {
    logic             vld;
    logic             live;   // entry has been written since reset
    logic             last;
    logic [TAP_W-1:0] k;
  } tap_t;

  // coefficient of tap k, mirrored and rescaled to q1.(COEF_WIDTH-1)
  function automatic logic signed [COEF_WIDTH-1:0] coef_at(input logic [TAP_W-1:0] k);
    logic signed [CW_MAX-1:0] ext;
    logic [ROM_IDX_W-1:0]     idx;
    idx = '0;
    ext = '0;
    if (int'(k) < ROM_LEN) begin
      idx = (int'(k) < ROM_HALF) ? ROM_IDX_W'(k) : ROM_IDX_W'(ROM_LEN - 1 - int'(k));
      ext = CW_MAX'(ROM_TBL[idx]);
      ext = (ext <<< COEF_UP) >>> COEF_DN;
    end
    return ext[COEF_WIDTH-1:0];
  endfunction

endpackage

@@ rtl/firc_delay_ram.sv @@
// ----------------------------------------------------------------------------
// firc_delay_ram: circular sample store
// one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module firc_delay_ram (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [firc_pkg::TAP_W-1:0]             waddr,
  input  logic signed [firc_pkg::SAMPLE_W-1:0]   wdata,
  input  logic [firc_pkg::TAP_W-1:0]             raddr,
  output logic signed [firc_pkg::SAMPLE_W-1:0]   rdata
);

  logic signed [firc_pkg::SAMPLE_W-1:0] mem [firc_pkg::TAPS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/firc_mac.sv @@
// ----------------------------------------------------------------------------
// firc_mac: multiply-accumulate datapath
// coefficient lookup and product register, then full-width accumulator
// ----------------------------------------------------------------------------
module firc_mac (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 clear,
  input  firc_pkg::tap_t                       tap,
  input  logic signed [firc_pkg::SAMPLE_W-1:0] sample,
  output logic signed [firc_pkg::ACC_W-1:0]    acc,
  output logic                                 done
);

  logic signed [firc_pkg::COEF_WIDTH-1:0] coef;
  logic signed [firc_pkg::PROD_W-1:0]     prod_nxt;
  logic signed [firc_pkg::PROD_W-1:0]     prod_r;
  firc_pkg::tap_t                         tap_r;
  logic signed [firc_pkg::ACC_W-1:0]      acc_r;
  logic                                   done_r;

  always_comb begin
    coef     = firc_pkg::coef_at(tap.k);
    prod_nxt = '0;
    if (tap.live) begin
      prod_nxt = coef * sample;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_r  <= '0;
      acc_r  <= '0;
      done_r <= 1'b0;
    end else begin
      tap_r  <= tap;
      done_r <= tap_r.vld && tap_r.last;
      if (clear) begin
        acc_r <= '0;
      end else if (tap_r.vld) begin
        acc_r <= acc_r + firc_pkg::ACC_W'(prod_r);
      end
    end
  end

  assign acc  = acc_r;
  assign done = done_r;

endmodule

@@ rtl/fir_filter_circular.sv @@
// throughput: a new sample is taken only in ST_IDLE, after the last result went to the
//   output register; the single delay ram read port feeds one multiply-accumulate per
//   tap, one tap per cycle; a result that finds the previous word still untaken waits
//   for out_tready and holds off the next sample
// reset: synchronous active-low rst_n clears control state; a fill count makes
//   never-written delay entries contribute zero products, so no clearing pass is needed
// ----------------------------------------------------------------------------
// fir_filter_circular: 121-tap direct form fir over a circular delay ram
// one shared mac walks the taps newest sample first, output is saturated
// ----------------------------------------------------------------------------
module fir_filter_circular (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // [15:0] sample_out
);

  localparam logic [firc_pkg::TAP_W-1:0]  LAST_ADDR = firc_pkg::TAP_W'(firc_pkg::TAPS - 1);
  localparam logic [firc_pkg::FILL_W-1:0] FILL_MAX  = firc_pkg::FILL_W'(firc_pkg::TAPS);

  firc_pkg::state_t                    state_r, state_nxt;
  logic [firc_pkg::TAP_W-1:0]          wr_pos_r, wr_pos_nxt;   // slot for the next sample
  logic [firc_pkg::FILL_W-1:0]         fill_r, fill_nxt;       // entries written since reset
  logic [firc_pkg::TAP_W-1:0]          rd_addr_r, rd_addr_nxt; // walks backward from newest
  logic [firc_pkg::TAP_W-1:0]          tap_cnt_r, tap_cnt_nxt;
  firc_pkg::tap_t                      tap_r, tap_nxt;
  logic                                res_rdy_r, res_rdy_nxt; // accumulator holds a result
  logic                                out_vld_r, out_vld_nxt;
  logic signed [firc_pkg::SAMPLE_W-1:0] out_data_r, out_data_nxt;

  logic                                 accept;
  logic                                 load_out;
  logic signed [firc_pkg::SAMPLE_W-1:0] rd_data;
  logic signed [firc_pkg::ACC_W-1:0]    acc;
  logic signed [firc_pkg::ACC_W-1:0]    scaled;
  logic                                 mac_done;

  // no word is taken while reset is held
  assign in_tready = rst_n && (state_r == firc_pkg::ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // sample goes into the ram on the accept edge, reads start the cycle after
  firc_delay_ram u_ram (
    .clk   (clk),
    .we    (accept),
    .waddr (wr_pos_r),
    .wdata (in_tdata),
    .raddr (rd_addr_r),
    .rdata (rd_data)
  );

  firc_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .clear  (accept),
    .tap    (tap_r),
    .sample (rd_data),
    .acc    (acc),
    .done   (mac_done)
  );

  // drop the fraction bits (floor) and clamp to the sample range
  always_comb begin
    scaled       = acc >>> firc_pkg::FRAC_W;
    out_data_nxt = out_data_r;
    if (scaled > firc_pkg::SAT_HI) begin
      out_data_nxt = firc_pkg::SAT_HI[firc_pkg::SAMPLE_W-1:0];
    end else if (scaled < firc_pkg::SAT_LO) begin
      out_data_nxt = firc_pkg::SAT_LO[firc_pkg::SAMPLE_W-1:0];
    end else begin
      out_data_nxt = scaled[firc_pkg::SAMPLE_W-1:0];
    end
  end

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    wr_pos_nxt  = wr_pos_r;
    fill_nxt    = fill_r;
    rd_addr_nxt = rd_addr_r;
    tap_cnt_nxt = tap_cnt_r;
    tap_nxt     = '0;
    res_rdy_nxt = res_rdy_r || mac_done;
    load_out    = 1'b0;
    out_vld_nxt = out_vld_r && !out_tready;

    unique case (state_r)
      firc_pkg::ST_IDLE: begin
        if (accept) begin
          rd_addr_nxt = wr_pos_r;
          tap_cnt_nxt = '0;
          wr_pos_nxt  = (wr_pos_r == LAST_ADDR) ? '0 : wr_pos_r + 1'b1;
          if (fill_r != FILL_MAX) begin
            fill_nxt = fill_r + 1'b1;
          end
          state_nxt = firc_pkg::ST_RUN;
        end
      end
      firc_pkg::ST_RUN: begin
        tap_nxt.vld  = 1'b1;
        tap_nxt.live = firc_pkg::FILL_W'(rd_addr_r) < fill_r;
        tap_nxt.last = (tap_cnt_r == LAST_ADDR);
        tap_nxt.k    = tap_cnt_r;
        rd_addr_nxt  = (rd_addr_r == '0) ? LAST_ADDR : rd_addr_r - 1'b1;
        tap_cnt_nxt  = tap_cnt_r + 1'b1;
        if (tap_cnt_r == LAST_ADDR) begin
          state_nxt = firc_pkg::ST_WAIT;
        end
      end
      firc_pkg::ST_WAIT: begin
        // hand the sum to the output register once it has room
        if (res_rdy_r && (!out_vld_r || out_tready)) begin
          load_out    = 1'b1;
          res_rdy_nxt = 1'b0;
          out_vld_nxt = 1'b1;
          state_nxt   = firc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = firc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= firc_pkg::ST_IDLE;
      wr_pos_r  <= '0;
      fill_r    <= '0;
      rd_addr_r <= '0;
      tap_cnt_r <= '0;
      tap_r     <= '0;
      res_rdy_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      wr_pos_r  <= wr_pos_nxt;
      fill_r    <= fill_nxt;
      rd_addr_r <= rd_addr_nxt;
      tap_cnt_r <= tap_cnt_nxt;
      tap_r     <= tap_nxt;
      res_rdy_r <= res_rdy_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

`ifndef ASSERT_OFF
  // an accepted word always starts a tap walk
  a_accept_runs: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == firc_pkg::ST_RUN))
    else $error("accepted word did not start the tap walk");

  // the mac finishes only after the last tap was issued
  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mac_done |-> (state_r == firc_pkg::ST_WAIT))
    else $error("mac finished outside the wait state");

  // the output register is never overwritten while its word is unread
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_vld_r || out_tready))
    else $error("result loaded over an untaken word");

  // fill count never passes the tap count
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_MAX)
    else $error("fill count out of range");
`endif

endmodule
